// ===== hw/rtl/alucf_pkg.sv =====
// Shared types, operation and condition codes for the ALU with condition flags.
package alucf_pkg;

  localparam int unsigned DATA_W = 32;

  typedef logic [DATA_W-1:0] word_t;

  localparam logic [1:0] REQ_DATA = 2'd0;
  localparam logic [1:0] REQ_MUL  = 2'd1;

  localparam logic [4:0] OP_AND  = 5'd0;
  localparam logic [4:0] OP_XOR  = 5'd1;
  localparam logic [4:0] OP_SUB  = 5'd2;
  localparam logic [4:0] OP_RSB  = 5'd3;
  localparam logic [4:0] OP_ADD  = 5'd4;
  localparam logic [4:0] OP_ADC  = 5'd5;
  localparam logic [4:0] OP_SBC  = 5'd6;
  localparam logic [4:0] OP_RSC  = 5'd7;
  localparam logic [4:0] OP_CAND = 5'd8;
  localparam logic [4:0] OP_CXOR = 5'd9;
  localparam logic [4:0] OP_CSUB = 5'd10;
  localparam logic [4:0] OP_CADD = 5'd11;
  localparam logic [4:0] OP_ORR  = 5'd12;
  localparam logic [4:0] OP_MOV  = 5'd13;
  localparam logic [4:0] OP_CLB  = 5'd14;
  localparam logic [4:0] OP_MVN  = 5'd15;
  localparam logic [4:0] OP_MUL  = 5'd16;

  localparam logic [3:0] CC_EQ  = 4'd0;
  localparam logic [3:0] CC_NE  = 4'd1;
  localparam logic [3:0] CC_UGE = 4'd2;
  localparam logic [3:0] CC_ULT = 4'd3;
  localparam logic [3:0] CC_N   = 4'd4;
  localparam logic [3:0] CC_NN  = 4'd5;
  localparam logic [3:0] CC_OV  = 4'd6;
  localparam logic [3:0] CC_NV  = 4'd7;
  localparam logic [3:0] CC_UGT = 4'd8;
  localparam logic [3:0] CC_ULE = 4'd9;
  localparam logic [3:0] CC_SGE = 4'd10;
  localparam logic [3:0] CC_SLT = 4'd11;
  localparam logic [3:0] CC_SGT = 4'd12;
  localparam logic [3:0] CC_SLE = 4'd13;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } nzcv_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [4:0] alu_op;
    logic       set_flags;
    logic       dest_is_pc;
    logic [3:0] cond_code;
    word_t      operand_a;
    word_t      operand_b;
    word_t      addend;
    logic       shifter_carry;
  } req_t;

  typedef struct packed {
    word_t result;
    logic  cond_passed;
    nzcv_t flags;
  } res_t;

  function automatic logic cond_holds(nzcv_t f, logic [3:0] code);
    logic ok;
    case (code)
      CC_EQ:   ok = f.z;
      CC_NE:   ok = !f.z;
      CC_UGE:  ok = f.c;
      CC_ULT:  ok = !f.c;
      CC_N:    ok = f.n;
      CC_NN:   ok = !f.n;
      CC_OV:   ok = f.v;
      CC_NV:   ok = !f.v;
      CC_UGT:  ok = f.c && !f.z;
      CC_ULE:  ok = !f.c || f.z;
      CC_SGE:  ok = (f.n == f.v);
      CC_SLT:  ok = (f.n != f.v);
      CC_SGT:  ok = !f.z && (f.n == f.v);
      CC_SLE:  ok = f.z || (f.n != f.v);
      default: ok = 1'b1;
    endcase
    return ok;
  endfunction

endpackage

// ===== hw/rtl/alucf_in_reg.sv =====
// Input request register with its valid bit and upstream stall.
module alucf_in_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  alucf_pkg::req_t  in_req,
  input  logic             adv,
  output logic             s1_valid,
  output alucf_pkg::req_t  s1_req
);
  import alucf_pkg::*;

  logic valid_r, valid_nxt;
  req_t req_r;
  logic load;

  assign in_stall = valid_r && !adv;
  assign load     = in_valid && !in_stall;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      req_r <= in_req;
    end
  end

  assign s1_valid = valid_r;
  assign s1_req   = req_r;

endmodule

// ===== hw/rtl/alucf_exec.sv =====
// Result, flag update and condition check for one request.
module alucf_exec (
  input  alucf_pkg::req_t  req,
  input  alucf_pkg::nzcv_t flags_old,
  output alucf_pkg::res_t  res
);
  import alucf_pkg::*;

  word_t        x, y;
  logic         cin;
  logic         arith;
  logic [DATA_W:0] sum;
  word_t        mul_lo;
  word_t        r;
  logic         co, ov;
  logic         upd_data, skip;
  nzcv_t        f;

  always_comb begin
    x     = req.operand_a;
    y     = req.operand_b;
    cin   = 1'b0;
    arith = 1'b0;
    case (req.alu_op)
      OP_SUB, OP_CSUB: begin
        y = ~req.operand_b; cin = 1'b1; arith = 1'b1;
      end
      OP_RSB: begin
        x = req.operand_b; y = ~req.operand_a; cin = 1'b1; arith = 1'b1;
      end
      OP_ADD, OP_CADD: begin
        arith = 1'b1;
      end
      OP_ADC: begin
        cin = flags_old.c; arith = 1'b1;
      end
      OP_SBC: begin
        y = ~req.operand_b; cin = flags_old.c; arith = 1'b1;
      end
      OP_RSC: begin
        x = req.operand_b; y = ~req.operand_a; cin = flags_old.c; arith = 1'b1;
      end
      default: begin
        arith = 1'b0;
      end
    endcase
  end

  assign sum    = {1'b0, x} + {1'b0, y} + {{DATA_W{1'b0}}, cin};
  assign co     = sum[DATA_W];
  assign ov     = (x[DATA_W-1] == y[DATA_W-1]) && (sum[DATA_W-1] != x[DATA_W-1]);
  assign mul_lo = req.operand_a * req.operand_b;

  always_comb begin
    case (req.alu_op)
      OP_AND, OP_CAND: r = req.operand_a & req.operand_b;
      OP_XOR, OP_CXOR: r = req.operand_a ^ req.operand_b;
      OP_SUB, OP_CSUB, OP_RSB, OP_ADD, OP_CADD, OP_ADC, OP_SBC, OP_RSC:
        r = sum[DATA_W-1:0];
      OP_ORR:  r = req.operand_a | req.operand_b;
      OP_MOV:  r = req.operand_b;
      OP_CLB:  r = req.operand_a & ~req.operand_b;
      OP_MVN:  r = ~req.operand_b;
      OP_MUL:  r = mul_lo + req.addend;
      default: r = req.operand_b;
    endcase
  end

  assign upd_data = (req.req_type == REQ_DATA) && req.set_flags && !req.dest_is_pc;
  assign skip     = ((req.alu_op == OP_MOV) || (req.alu_op == OP_MVN)) &&
                    !cond_holds(flags_old, req.cond_code);

  always_comb begin
    f = flags_old;
    if (upd_data) begin
      if (!skip) begin
        f.n = r[DATA_W-1];
        f.z = (r == '0);
        if (arith) begin
          f.c = co;
          f.v = ov;
        end else begin
          f.c = req.shifter_carry;
        end
      end
    end else if ((req.req_type == REQ_MUL) && req.set_flags) begin
      f.n = r[DATA_W-1];
      f.z = (r == '0);
    end
  end

  assign res.result      = r;
  assign res.flags       = f;
  assign res.cond_passed = cond_holds(f, req.cond_code);

endmodule

// ===== hw/rtl/alucf_out_reg.sv =====
// Output result register with its valid bit and pipeline advance.
module alucf_out_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            s1_valid,
  input  alucf_pkg::res_t d,
  output logic            adv,
  output logic            out_valid,
  input  logic            out_stall,
  output alucf_pkg::res_t q
);
  import alucf_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r;

  assign adv = !(valid_r && out_stall);

  always_comb begin
    if (adv) begin
      valid_nxt = s1_valid;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      res_r <= d;
    end
  end

  assign out_valid = valid_r;
  assign q         = res_r;

endmodule

// ===== hw/rtl/alu_with_condition_flags.sv =====
// Top level: 32-bit execute unit keeping N, Z, C and V condition flags.
// Path: a request passes the input register, then the result register; the flag
// register is written as a request leaves the input stage.
// Throughput: one request per cycle while out_stall is low; flags loop through the adder.
// Reset: synchronous, active low; clears both valid bits and the flags to zero.
module alu_with_condition_flags (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic [4:0]         in_alu_op,
  input  logic               in_set_flags,
  input  logic               in_dest_is_pc,
  input  logic [3:0]         in_cond_code,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  input  logic signed [31:0] in_addend,
  input  logic               in_shifter_carry,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_result,
  output logic               out_cond_passed,
  output logic               out_flag_n,
  output logic               out_flag_z,
  output logic               out_flag_c,
  output logic               out_flag_v
);
  import alucf_pkg::*;

  req_t  in_req;
  req_t  s1_req;
  logic  s1_valid;
  logic  adv;
  res_t  ex_res;
  res_t  out_res;
  nzcv_t flags_r, flags_nxt;

  assign in_req.req_type      = in_req_type;
  assign in_req.alu_op        = in_alu_op;
  assign in_req.set_flags     = in_set_flags;
  assign in_req.dest_is_pc    = in_dest_is_pc;
  assign in_req.cond_code     = in_cond_code;
  assign in_req.operand_a     = in_operand_a;
  assign in_req.operand_b     = in_operand_b;
  assign in_req.addend        = in_addend;
  assign in_req.shifter_carry = in_shifter_carry;

  alucf_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_req   (s1_req)
  );

  alucf_exec u_exec (
    .req       (s1_req),
    .flags_old (flags_r),
    .res       (ex_res)
  );

  alucf_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .d         (ex_res),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .q         (out_res)
  );

  // advance the flags as each request leaves the input stage
  assign flags_nxt = (s1_valid && adv) ? ex_res.flags : flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
  end

  assign out_result      = out_res.result;
  assign out_cond_passed = out_res.cond_passed;
  assign out_flag_n      = out_res.flags.n;
  assign out_flag_z      = out_res.flags.z;
  assign out_flag_c      = out_res.flags.c;
  assign out_flag_v      = out_res.flags.v;

endmodule

// ===== hw/rtl/alucf_checker.sv =====
// Port-level checker for the ALU with condition flags, bound to the top level.
module alucf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_result
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("request stalled without downstream back-pressure");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall && in_valid && !in_stall ##1 out_stall |-> in_stall)
    else $error("request taken with both stages full");

  a_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> ##1 out_valid)
    else $error("accepted request did not reach the output");

endmodule

bind alu_with_condition_flags alucf_checker u_alucf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_result (out_result)
);
